[hw/rtl/tadm_pkg.sv]
// Shared types, codes and helpers for the throttling admission queue.
// No dependencies; imported by tadm_delay and throttling_admission_queue.
package tadm_pkg;

    localparam int QDEPTH = 16;
    localparam int QW     = 4;
    localparam int CW     = 5;

    localparam logic [19:0] MAX_DELAY = 20'd1000000;
    localparam logic [19:0] NEAR_ONE  = 20'd999999;
    localparam logic [23:0] LEVEL_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        OP_LOCK   = 3'd0,
        OP_UNLOCK = 3'd1,
        OP_FORCE  = 3'd2,
        OP_TICK   = 3'd3,
        OP_CANCEL = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        EV_ACK      = 3'd0,
        EV_GRANTED  = 3'd1,
        EV_QUEUED   = 3'd2,
        EV_CANCELED = 3'd3,
        EV_NOTFOUND = 3'd4,
        EV_FULL     = 3'd5,
        EV_UNDER    = 3'd6
    } ev_t;

    typedef enum logic [2:0] {
        REG_CAPACITY  = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_DELAYHALF = 3'd2,
        REG_GRAN      = 3'd3,
        REG_ORDER     = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LK_WAIT, ST_EMIT, ST_WC_INIT, ST_WC_SCAN, ST_C_SRCH, ST_SHIFT,
        ST_R_LOOP, ST_R_AGE, ST_R_CHK, ST_R_DLY, ST_R_DEC, ST_R_FIN
    } state_t;

    typedef enum logic [2:0] {
        D_IDLE, D_THR, D_CHK, D_M1, D_M2, D_CMP, D_DIV, D_CAP
    } dstate_t;

    typedef struct packed {
        logic        start;
        logic [23:0] capacity;
        logic [15:0] frac;
        logic [19:0] dah;
        logic [23:0] level;
    } dly_req_t;

    typedef struct packed {
        logic        done;
        logic [19:0] delay;
    } dly_rsp_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function automatic logic [23:0] level_add(input logic [23:0] l, input logic [15:0] u);
        logic [24:0] s;
        s = {1'b0, l} + {9'b0, u};
        return s[24] ? LEVEL_MAX : s[23:0];
    endfunction

endpackage

[hw/rtl/throttling_admission_queue.sv]
// Top level of the throttling admission queue: APB registers, waiter queue, sequencer.
// Depends on tadm_pkg and tadm_delay.
//
//  channel   | dir | contents
//  s_*       | in  | request: operation, units, requester_tag
//  m_*       | out | result: event_res, tag_out, level; tlast ends a request
//  APB       | in  | capacity, threshold fraction, half-way delay, wakeup interval, order mode
//
// One request at a time; s_tready is high only while the sequencer is idle.
// A lock runs the delay unit (threshold, checks and up to a 44-step divide); a queued
// lock then scans the queue. A wakeup walk may run a delay computation and a shift
// pass per waiter. Results wait in one output register; a stall holds the sequencer
// at its next result. Reset empties the queue and loads register defaults.
module throttling_admission_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operation[2:0], units[18:3], requester_tag[26:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // event_res[2:0], tag_out[10:3], level[34:11]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tadm_pkg::*;

    state_t      state_reg, state_next;
    logic [23:0] cap_reg;
    logic [15:0] frac_reg;
    logic [19:0] dah_reg;
    logic [19:0] gran_reg;
    logic        keep_reg;
    logic [23:0] level_reg, level_next;
    logic [CW-1:0] count_reg, count_next;
    logic        run_reg, run_next;
    logic [19:0] wake_reg, wake_next;
    logic [31:0] sring_reg, sring_next;
    logic [2:0]  op_reg, op_next;
    logic [15:0] units_reg, units_next;
    logic [7:0]  tag_reg, tag_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [31:0] passed_reg, passed_next;
    logic [19:0] nxt_reg, nxt_next;
    ev_t         res_reg, res_next;
    logic        pend_v_reg, pend_v_next;
    logic [7:0]  pend_tag_reg, pend_tag_next;
    logic [23:0] pend_lvl_reg, pend_lvl_next;
    logic        out_v_reg, out_v_next;
    logic [2:0]  out_ev_reg, out_ev_next;
    logic [7:0]  out_tag_reg, out_tag_next;
    logic [23:0] out_lvl_reg, out_lvl_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  w_tag    [QDEPTH];
    logic [15:0] w_units  [QDEPTH];
    logic [19:0] w_target [QDEPTH];
    logic [31:0] w_waited [QDEPTH];
    logic [31:0] w_since  [QDEPTH];
    logic [31:0] w_period [QDEPTH];

    dly_req_t    dreq;
    dly_rsp_t    drsp;
    logic        dly_start;
    logic [CW-1:0] sh_inc;
    logic [QW-1:0] rd;
    logic        out_free;
    logic        cfg_wr;
    logic [31:0] sinc;
    logic [19:0] left;
    logic [19:0] mn;
    logic        due;
    logic [2:0]  in_op;
    logic [15:0] in_units;
    logic [7:0]  in_tag;

    tadm_delay u_delay
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign dreq.start    = dly_start;
    assign dreq.capacity = cap_reg;
    assign dreq.frac     = frac_reg;
    assign dreq.dah      = dah_reg;
    assign dreq.level    = level_reg;

    assign in_op    = s_tdata[2:0];
    assign in_units = s_tdata[18:3];
    assign in_tag   = s_tdata[26:19];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'b0, out_lvl_reg, out_tag_reg, out_ev_reg};
    assign m_tlast  = out_last_reg;
    assign out_free = !out_v_reg || m_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CAPACITY:  prdata = {8'b0, cap_reg};
            REG_THRESHOLD: prdata = {16'b0, frac_reg};
            REG_DELAYHALF: prdata = {12'b0, dah_reg};
            REG_GRAN:      prdata = {12'b0, gran_reg};
            REG_ORDER:     prdata = {31'b0, keep_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= 24'd1000;
            frac_reg <= 16'd32768;
            dah_reg  <= 20'd100;
            gran_reg <= 20'd10;
            keep_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_CAPACITY:  cap_reg  <= pwdata[23:0];
                REG_THRESHOLD: frac_reg <= pwdata[15:0];
                REG_DELAYHALF: dah_reg  <= pwdata[19:0];
                REG_GRAN:      gran_reg <= pwdata[19:0];
                REG_ORDER:     keep_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    assign sh_inc = sh_reg + CW'(1);
    assign rd     = (state_reg == ST_SHIFT) ? sh_inc[QW-1:0] : idx_reg[QW-1:0];
    assign sinc   = sat_add32(sring_reg, 32'd1);
    assign left   = ({12'b0, w_target[rd]} > w_waited[rd]) ?
                    20'(w_target[rd] - w_waited[rd][19:0]) : 20'd1;
    assign mn     = (left < nxt_reg) ? left : nxt_reg;
    assign due    = (w_waited[rd] >= {12'b0, w_target[rd]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            level_reg  <= 24'd0;
            count_reg  <= '0;
            run_reg    <= 1'b0;
            wake_reg   <= 20'd0;
            sring_reg  <= 32'd0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            count_reg  <= count_next;
            run_reg    <= run_next;
            wake_reg   <= wake_next;
            sring_reg  <= sring_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        units_reg    <= units_next;
        tag_reg      <= tag_next;
        idx_reg      <= idx_next;
        sh_reg       <= sh_next;
        passed_reg   <= passed_next;
        nxt_reg      <= nxt_next;
        res_reg      <= res_next;
        pend_tag_reg <= pend_tag_next;
        pend_lvl_reg <= pend_lvl_next;
        out_ev_reg   <= out_ev_next;
        out_tag_reg  <= out_tag_next;
        out_lvl_reg  <= out_lvl_next;
        out_last_reg <= out_last_next;
    end

    // waiter queue storage
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LK_WAIT && drsp.done && drsp.delay != 20'd0
            && count_reg != CW'(QDEPTH))
        begin
            w_tag[count_reg[QW-1:0]]    <= tag_reg;
            w_units[count_reg[QW-1:0]]  <= units_reg;
            w_target[count_reg[QW-1:0]] <= drsp.delay;
            w_waited[count_reg[QW-1:0]] <= 32'd0;
            w_since[count_reg[QW-1:0]]  <= 32'd0;
            w_period[count_reg[QW-1:0]] <= {12'b0, gran_reg};
        end
        if (state_reg == ST_R_AGE)
        begin
            w_waited[rd] <= sat_add32(w_waited[rd], passed_reg);
            w_since[rd]  <= sat_add32(w_since[rd], passed_reg);
        end
        if (state_reg == ST_R_DLY && drsp.done)
        begin
            w_target[rd] <= drsp.delay;
            w_period[rd] <= sat_add32(w_period[rd], w_period[rd]);
        end
        if (state_reg == ST_SHIFT && sh_inc < count_reg)
        begin
            w_tag[sh_reg[QW-1:0]]    <= w_tag[rd];
            w_units[sh_reg[QW-1:0]]  <= w_units[rd];
            w_target[sh_reg[QW-1:0]] <= w_target[rd];
            w_waited[sh_reg[QW-1:0]] <= w_waited[rd];
            w_since[sh_reg[QW-1:0]]  <= w_since[rd];
            w_period[sh_reg[QW-1:0]] <= w_period[rd];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        count_next    = count_reg;
        run_next      = run_reg;
        wake_next     = wake_reg;
        sring_next    = sring_reg;
        op_next       = op_reg;
        units_next    = units_reg;
        tag_next      = tag_reg;
        idx_next      = idx_reg;
        sh_next       = sh_reg;
        passed_next   = passed_reg;
        nxt_next      = nxt_reg;
        res_next      = res_reg;
        pend_v_next   = pend_v_reg;
        pend_tag_next = pend_tag_reg;
        pend_lvl_next = pend_lvl_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_ev_next   = out_ev_reg;
        out_tag_next  = out_tag_reg;
        out_lvl_next  = out_lvl_reg;
        out_last_next = out_last_reg;
        dly_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    units_next = in_units;
                    tag_next   = in_tag;
                    res_next   = EV_ACK;
                    state_next = ST_EMIT;
                    unique case (in_op)
                        OP_LOCK:
                        begin
                            dly_start  = 1'b1;
                            state_next = ST_LK_WAIT;
                        end
                        OP_UNLOCK:
                        begin
                            if ({8'b0, in_units} > level_reg)
                            begin
                                level_next = 24'd0;
                                res_next   = EV_UNDER;
                            end
                            else
                                level_next = level_reg - {8'b0, in_units};
                        end
                        OP_FORCE:
                            level_next = level_add(level_reg, in_units);
                        OP_TICK:
                        begin
                            tag_next = 8'd0;
                            if (run_reg)
                            begin
                                if (wake_reg <= 20'd1)
                                begin
                                    passed_next = sinc;
                                    sring_next  = 32'd0;
                                    idx_next    = '0;
                                    state_next  = ST_R_LOOP;
                                end
                                else
                                begin
                                    sring_next = sinc;
                                    wake_next  = wake_reg - 20'd1;
                                end
                            end
                        end
                        OP_CANCEL:
                        begin
                            idx_next   = '0;
                            state_next = ST_C_SRCH;
                        end
                        default:
                            tag_next = 8'd0;
                    endcase
                end
            end
            ST_LK_WAIT:
            begin
                if (drsp.done)
                begin
                    if (drsp.delay == 20'd0)
                    begin
                        level_next = level_add(level_reg, units_reg);
                        res_next   = EV_GRANTED;
                        state_next = ST_EMIT;
                    end
                    else if (count_reg == CW'(QDEPTH))
                    begin
                        res_next   = EV_FULL;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        res_next   = EV_QUEUED;
                        state_next = ST_WC_INIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_ev_next   = res_reg;
                    out_tag_next  = tag_reg;
                    out_lvl_next  = level_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WC_INIT:
            begin
                if (count_reg == '0)
                begin
                    run_next   = 1'b0;
                    wake_next  = 20'd0;
                    state_next = (op_reg == OP_TICK) ? ST_R_FIN : ST_EMIT;
                end
                else
                begin
                    if (!run_reg)
                    begin
                        run_next   = 1'b1;
                        sring_next = 32'd0;
                    end
                    nxt_next   = (gran_reg == 20'd0) ? 20'd1 : gran_reg;
                    idx_next   = '0;
                    state_next = ST_WC_SCAN;
                end
            end
            ST_WC_SCAN:
            begin
                if (keep_reg || idx_reg + CW'(1) == count_reg)
                begin
                    wake_next  = mn;
                    state_next = (op_reg == OP_TICK) ? ST_R_FIN : ST_EMIT;
                end
                else
                begin
                    nxt_next = mn;
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_C_SRCH:
            begin
                if (idx_reg == count_reg)
                begin
                    res_next   = EV_NOTFOUND;
                    state_next = ST_EMIT;
                end
                else if (w_tag[rd] == tag_reg)
                begin
                    sh_next    = idx_reg;
                    res_next   = EV_CANCELED;
                    state_next = ST_SHIFT;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            ST_SHIFT:
            begin
                if (sh_inc < count_reg)
                    sh_next = sh_inc;
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = (op_reg == OP_TICK) ? ST_R_LOOP : ST_WC_INIT;
                end
            end
            ST_R_LOOP:
                state_next = (idx_reg < count_reg) ? ST_R_AGE : ST_WC_INIT;
            ST_R_AGE:
                state_next = ST_R_CHK;
            ST_R_CHK:
            begin
                if (w_since[rd] >= w_period[rd] || due)
                begin
                    dly_start  = 1'b1;
                    state_next = ST_R_DLY;
                end
                else
                    state_next = ST_R_DEC;
            end
            ST_R_DLY:
            begin
                if (drsp.done)
                    state_next = ST_R_DEC;
            end
            ST_R_DEC:
            begin
                if (due)
                begin
                    if (!pend_v_reg || out_free)
                    begin
                        if (pend_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_ev_next   = EV_GRANTED;
                            out_tag_next  = pend_tag_reg;
                            out_lvl_next  = pend_lvl_reg;
                            out_last_next = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_tag_next = w_tag[rd];
                        pend_lvl_next = level_add(level_reg, w_units[rd]);
                        level_next    = level_add(level_reg, w_units[rd]);
                        sh_next       = idx_reg;
                        state_next    = ST_SHIFT;
                    end
                end
                else if (keep_reg)
                    state_next = ST_WC_INIT;
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_R_LOOP;
                end
            end
            ST_R_FIN:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_v_reg)
                    begin
                        out_ev_next  = EV_GRANTED;
                        out_tag_next = pend_tag_reg;
                        out_lvl_next = pend_lvl_reg;
                        pend_v_next  = 1'b0;
                    end
                    else
                    begin
                        out_ev_next  = EV_ACK;
                        out_tag_next = 8'd0;
                        out_lvl_next = level_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QDEPTH))
        else $error("waiter count beyond queue depth");

    a_timer_with_waiters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && count_reg != '0) |-> run_reg)
        else $error("waiters queued with wakeup timer stopped");

    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("grant left pending after walk");

    a_delay_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == ST_LK_WAIT || state_reg == ST_R_DLY))
        else $error("delay result with no request waiting");

endmodule

[hw/rtl/tadm_delay.sv]
// Target delay unit: threshold, saturation checks and a bit-serial divide.
// Depends on tadm_pkg.
module tadm_delay
(
    input  logic              clk,
    input  logic              rst_n,
    input  tadm_pkg::dly_req_t req,
    output tadm_pkg::dly_rsp_t rsp
);
    import tadm_pkg::*;

    dstate_t     st_reg, st_next;
    logic [23:0] lvl_reg, lvl_next;
    logic [23:0] t_reg, t_next;
    logic [23:0] a_reg, a_next;
    logic [23:0] b_reg, b_next;
    logic [23:0] den_reg, den_next;
    logic [23:0] rem_reg, rem_next;
    logic [43:0] m1_reg, m1_next;
    logic [43:0] m2_reg, m2_next;
    logic [43:0] num_reg, num_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [19:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [39:0] thr_prod;
    logic [24:0] rem_sh;

    assign thr_prod = {16'b0, req.capacity} * {24'b0, req.frac};
    assign rem_sh   = {rem_reg, num_reg[43]};
    assign rsp.done  = done_reg;
    assign rsp.delay = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        t_reg   <= t_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        num_reg <= num_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        lvl_next  = lvl_reg;
        t_next    = t_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        m1_next   = m1_reg;
        m2_next   = m2_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        unique case (st_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    lvl_next = req.level;
                    st_next  = D_THR;
                end
            end
            D_THR:
            begin
                t_next  = thr_prod[39:16];
                st_next = D_CHK;
            end
            D_CHK:
            begin
                if (lvl_reg < t_reg)
                begin
                    res_next  = 20'd0;
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end
                else if (lvl_reg >= req.capacity)
                begin
                    res_next  = MAX_DELAY;
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end
                else
                begin
                    a_next   = lvl_reg - t_reg;
                    b_next   = req.capacity - t_reg;
                    den_next = req.capacity - lvl_reg;
                    st_next  = D_M1;
                end
            end
            D_M1:
            begin
                m1_next = {20'b0, a_reg} * {24'b0, MAX_DELAY};
                st_next = D_M2;
            end
            D_M2:
            begin
                m2_next = {20'b0, b_reg} * {24'b0, NEAR_ONE};
                st_next = D_CMP;
            end
            D_CMP:
            begin
                if (m1_reg > m2_reg)
                begin
                    res_next  = MAX_DELAY;
                    done_next = 1'b1;
                    st_next   = D_IDLE;
                end
                else
                begin
                    num_next = {20'b0, a_reg} * {24'b0, req.dah};
                    rem_next = 24'd0;
                    cnt_next = 6'd0;
                    st_next  = D_DIV;
                end
            end
            D_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = 24'(rem_sh - {1'b0, den_reg});
                    num_next = {num_reg[42:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[23:0];
                    num_next = {num_reg[42:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd43)
                    st_next = D_CAP;
            end
            D_CAP:
            begin
                if (num_reg[43:20] != 24'd0 || num_reg[19:0] > MAX_DELAY)
                    res_next = MAX_DELAY;
                else
                    res_next = num_reg[19:0];
                done_next = 1'b1;
                st_next   = D_IDLE;
            end
            default:
                st_next = D_IDLE;
        endcase
    end

endmodule
